// ----- rtl/teu_pkg.sv -----
// Package for the timestamped encoder unwrap block: request and result types,
// register indexes, reset values and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package teu_pkg;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         channel;
    logic [31:0]        enc_count;
    logic [31:0]        time_stamp;
    logic signed [47:0] home_value;
  } teu_in_t;

  typedef struct packed {
    logic [1:0]         out_channel;
    logic signed [47:0] position;
    logic [31:0]        raw_count;
    logic               time_fault;
  } teu_out_t;

  localparam int NUM_CHANNELS_DEF   = 4;
  localparam int COUNT_BITS_DEF     = 32;
  localparam int CORR_FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_ENC_MOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_MOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN3    = 3'd6;

  localparam logic [32:0] ENC_MOD_RST  = 33'd65536;
  localparam logic [32:0] TIME_MOD_RST = 33'd65536;
  localparam logic [31:0] PERIOD_RST   = 32'd3906;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_TIME,
    ST_TIME2,
    ST_DIV,
    ST_PRIME,
    ST_PRIME_WB,
    ST_UNW1_WB,
    ST_UNW_ADJ,
    ST_UNW2_WB,
    ST_STEP,
    ST_ACC_WB,
    ST_SR_WB,
    ST_T2_WB,
    ST_FIN,
    ST_HOME_WB,
    ST_MULPREP,
    ST_MUL,
    ST_MULFIX
  } teu_state_t;

endpackage

// ----- rtl/timestamped_encoder_unwrap.sv -----
// Multi-turn encoder unwrap with time-stamp ratio correction, gain and homing.
// Depends on teu_pkg for the request and result types, register indexes and states.
//
// Usage: requests enter on in_valid/in_stall with in_data; results leave on
// out_valid/out_stall with out_data. A sample request gives one result; a home
// request or a request for a channel at or above NUM_CHANNELS gives none.
// Registers are written through cfg_wr_en, cfg_index and cfg_wdata; the user
// must write them only while idle, which the block itself does not enforce.
// One request is processed at a time by a sequencer around one shared 16 x 41
// bit multiplier (states MULPREP, MUL and MULFIX) and a one-bit-a-cycle
// divider. A channel 0 sample adds the time steps and, when needed, a ratio
// division of CORR_FRAC_BITS + 2 quotient bits; a first sample on a channel
// adds a priming product, and a home request runs one gain product.
// in_stall is high from acceptance until the result has been loaded into the
// output register, so the next request is taken while that result waits. If
// an earlier result still waits and the receiver holds out_stall, the block
// waits with a finished result in its last step and stalls the input.
// Synchronous reset clears all channel state, the time state and the registers
// to their reset values; no clearing pass is needed.
`timescale 1ns / 1ps

module timestamped_encoder_unwrap #(
  parameter int NUM_CHANNELS   = teu_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS     = teu_pkg::COUNT_BITS_DEF,
  parameter int CORR_FRAC_BITS = teu_pkg::CORR_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  teu_pkg::teu_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output teu_pkg::teu_out_t              out_data,
  input  logic                           cfg_wr_en,
  input  logic [teu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [teu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RW    = CORR_FRAC_BITS + 2;
  localparam int CH_IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DKW   = $clog2(RW + 1);
  localparam logic [RW-1:0] RATIO_ONE = RW'(1) << CORR_FRAC_BITS;
  localparam logic [RW-1:0] RATIO_MAX = '1;
  localparam logic signed [63:0] STEP_MAX = 64'sd68719476735;
  localparam logic signed [63:0] LIM61    = 64'sd2305843009213693952;

  teu_pkg::teu_state_t state_r, state_nxt, mul_ret_r, mul_ret_nxt;

  logic [32:0]        enc_mod_r, time_mod_r;
  logic [31:0]        period_r;
  logic signed [39:0] gain_r [0:3];

  logic [31:0]        turn_arr_r [NUM_CHANNELS];
  logic [63:0]        pext_arr_r [NUM_CHANNELS];
  logic signed [63:0] href_arr_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] primed_r;
  logic               arr_we;
  logic [31:0]        arr_turn_val;
  logic [63:0]        arr_pext_val;
  logic signed [63:0] arr_href_val;

  logic [31:0]        prev_time_r, prev_time_nxt;
  logic signed [47:0] shift_acc_r, shift_acc_nxt;
  logic [RW-1:0]      ratio_r, ratio_nxt;
  logic               time_primed_r, time_primed_nxt;

  teu_pkg::teu_in_t   item_r, item_nxt;
  logic               fault_r, fault_nxt;
  logic [31:0]        turn_w_r, turn_w_nxt;
  logic [63:0]        pext_w_r, pext_w_nxt;
  logic signed [63:0] href_w_r, href_w_nxt;
  logic [63:0]        ext_r, ext_nxt;
  logic signed [36:0] step_r, step_nxt;
  logic signed [63:0] prev_raw_r, prev_raw_nxt;
  logic signed [105:0] acc_r, acc_nxt;
  logic signed [63:0] pos64_r, pos64_nxt;
  logic signed [35:0] diff_r, diff_nxt;
  logic signed [49:0] num_r, num_nxt;
  logic [36:0]        rem_r, rem_nxt;
  logic [35:0]        dv_r, dv_nxt;
  logic [RW-1:0]      q_r, q_nxt;
  logic [DKW-1:0]     div_k_r, div_k_nxt;

  logic signed [63:0] mul_a_r, mul_a_nxt;
  logic signed [40:0] mul_b_r, mul_b_nxt;
  logic [63:0]        mag_a_r, mag_a_nxt;
  logic [40:0]        mag_b_r, mag_b_nxt;
  logic               mul_neg_r, mul_neg_nxt;
  logic [104:0]       mul_acc_r, mul_acc_nxt;
  logic [1:0]         mul_k_r, mul_k_nxt;
  logic signed [105:0] prod_r, prod_nxt;

  logic               out_valid_r, out_valid_nxt;
  teu_pkg::teu_out_t  out_data_r, out_data_nxt;

  logic               ch_ok;
  logic [CH_IW-1:0]   ch_idx;
  logic signed [39:0] gain_sel;
  logic [31:0]        cnt_w;
  logic signed [35:0] t_d36, t_diff;
  logic               t_wrap;
  logic [49:0]        a_mag;
  logic [35:0]        b_mag;
  logic               ratio_zero, need_div;
  logic signed [50:0] sa_sum;
  logic               div_ge;
  logic [36:0]        div_rem;
  logic [56:0]        mul_pp;
  logic [15:0]        mul_chunk;
  logic signed [65:0] home_diff, unw_d2, fin_diff;
  logic signed [63:0] prod_low, step_s64;
  logic [31:0]        turn_new;
  logic signed [106:0] t2_sum;
  logic               fin_fire;

  function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
    logic signed [63:0] r;
    if (v[65:63] == 3'b000 || v[65:63] == 3'b111) begin
      r = v[63:0];
    end else begin
      r = v[65] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  assign ch_ok    = (32'(item_r.channel) < NUM_CHANNELS);
  assign ch_idx   = CH_IW'(item_r.channel);
  assign gain_sel = gain_r[item_r.channel];
  assign cnt_w    = 32'(item_r.enc_count[COUNT_BITS-1:0]);

  assign t_d36  = $signed({4'b0, prev_time_r}) - $signed({4'b0, item_r.time_stamp});
  assign t_wrap = (t_d36 <<< 1) > $signed({3'b0, time_mod_r});
  assign t_diff = t_wrap ? ($signed({4'b0, item_r.time_stamp}) + $signed({3'b0, time_mod_r})
                           - $signed({4'b0, prev_time_r}))
                         : -t_d36;

  assign a_mag = num_r[49] ? 50'(-num_r) : 50'(num_r);
  assign b_mag = diff_r[35] ? 36'(-diff_r) : 36'(diff_r);
  assign ratio_zero = (num_r == '0) || ((!num_r[49]) != (!diff_r[35]));
  assign need_div = (diff_r != '0) && !ratio_zero && (a_mag < 50'({b_mag, 2'b00}));
  assign sa_sum = 51'(shift_acc_r) + 51'(diff_r) - $signed({19'b0, period_r});

  assign div_ge  = rem_r >= {1'b0, dv_r};
  assign div_rem = div_ge ? (rem_r - {1'b0, dv_r}) : rem_r;

  assign mul_chunk = mag_a_r[{mul_k_r, 4'b0000} +: 16];
  assign mul_pp    = {41'b0, mul_chunk} * {16'b0, mag_b_r};

  assign prod_low  = prod_r[63:0];
  assign home_diff = 66'($signed(prod_r[71:8])) - 66'(item_r.home_value);
  assign unw_d2    = (66'(prev_raw_r) - $signed({34'b0, cnt_w})) <<< 1;
  assign step_s64  = $signed(ext_r - pext_w_r);
  assign t2_sum    = 107'(acc_r) + (107'(prod_r) >>> CORR_FRAC_BITS);
  assign fin_diff  = 66'(pos64_r) - 66'(href_w_r);
  assign fin_fire  = !out_valid_r || !out_stall;

  always_comb begin
    turn_new = turn_w_r;
    if (prev_raw_r >= -LIM61 && prev_raw_r <= LIM61) begin
      if (unw_d2 > $signed({33'b0, enc_mod_r})) begin
        turn_new = turn_w_r + 32'd1;
      end else if (unw_d2 < -$signed({33'b0, enc_mod_r})) begin
        turn_new = turn_w_r - 32'd1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      teu_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = teu_pkg::ST_DISPATCH;
      end
      teu_pkg::ST_DISPATCH: begin
        if (!ch_ok) state_nxt = teu_pkg::ST_IDLE;
        else if (item_r.cmd) state_nxt = teu_pkg::ST_MULPREP;
        else if (item_r.channel == 2'd0) state_nxt = teu_pkg::ST_TIME;
        else state_nxt = teu_pkg::ST_PRIME;
      end
      teu_pkg::ST_TIME: begin
        state_nxt = time_primed_r ? teu_pkg::ST_TIME2 : teu_pkg::ST_PRIME;
      end
      teu_pkg::ST_TIME2: begin
        state_nxt = need_div ? teu_pkg::ST_DIV : teu_pkg::ST_PRIME;
      end
      teu_pkg::ST_DIV: begin
        if (div_k_r == DKW'(RW - 1)) state_nxt = teu_pkg::ST_PRIME;
      end
      teu_pkg::ST_PRIME, teu_pkg::ST_PRIME_WB, teu_pkg::ST_UNW_ADJ, teu_pkg::ST_STEP,
      teu_pkg::ST_ACC_WB, teu_pkg::ST_SR_WB: begin
        state_nxt = teu_pkg::ST_MULPREP;
      end
      teu_pkg::ST_UNW1_WB: state_nxt = teu_pkg::ST_UNW_ADJ;
      teu_pkg::ST_UNW2_WB: state_nxt = teu_pkg::ST_STEP;
      teu_pkg::ST_T2_WB:   state_nxt = teu_pkg::ST_FIN;
      teu_pkg::ST_FIN: begin
        if (fin_fire) state_nxt = teu_pkg::ST_IDLE;
      end
      teu_pkg::ST_HOME_WB: state_nxt = teu_pkg::ST_IDLE;
      teu_pkg::ST_MULPREP: state_nxt = teu_pkg::ST_MUL;
      teu_pkg::ST_MUL: begin
        if (mul_k_r == 2'd3) state_nxt = teu_pkg::ST_MULFIX;
      end
      teu_pkg::ST_MULFIX: state_nxt = mul_ret_r;
      default: state_nxt = teu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_nxt        = item_r;
    fault_nxt       = fault_r;
    prev_time_nxt   = prev_time_r;
    shift_acc_nxt   = shift_acc_r;
    ratio_nxt       = ratio_r;
    time_primed_nxt = time_primed_r;
    turn_w_nxt      = turn_w_r;
    pext_w_nxt      = pext_w_r;
    href_w_nxt      = href_w_r;
    ext_nxt         = ext_r;
    step_nxt        = step_r;
    prev_raw_nxt    = prev_raw_r;
    acc_nxt         = acc_r;
    pos64_nxt       = pos64_r;
    diff_nxt        = diff_r;
    num_nxt         = num_r;
    rem_nxt         = rem_r;
    dv_nxt          = dv_r;
    q_nxt           = q_r;
    div_k_nxt       = div_k_r;
    mul_a_nxt       = mul_a_r;
    mul_b_nxt       = mul_b_r;
    mul_ret_nxt     = mul_ret_r;
    mag_a_nxt       = mag_a_r;
    mag_b_nxt       = mag_b_r;
    mul_neg_nxt     = mul_neg_r;
    mul_acc_nxt     = mul_acc_r;
    mul_k_nxt       = mul_k_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    arr_we          = 1'b0;
    arr_turn_val    = turn_w_r;
    arr_pext_val    = ext_r;
    arr_href_val    = href_w_r;
    in_stall        = (state_r != teu_pkg::ST_IDLE);
    unique case (state_r)
      teu_pkg::ST_IDLE: begin
        item_nxt  = in_data;
        fault_nxt = 1'b0;
      end
      teu_pkg::ST_DISPATCH: begin
        mul_a_nxt   = $signed({32'b0, cnt_w});
        mul_b_nxt   = 41'(gain_sel);
        mul_ret_nxt = teu_pkg::ST_HOME_WB;
      end
      teu_pkg::ST_TIME: begin
        if (!time_primed_r) begin
          prev_time_nxt   = item_r.time_stamp;
          time_primed_nxt = 1'b1;
        end
        diff_nxt = t_diff;
        num_nxt  = $signed({18'b0, period_r}) - 50'(shift_acc_r);
      end
      teu_pkg::ST_TIME2: begin
        if (diff_r == '0) begin
          ratio_nxt = RATIO_ONE;
          fault_nxt = 1'b1;
        end else if (ratio_zero) begin
          ratio_nxt = '0;
        end else if (!need_div) begin
          ratio_nxt = RATIO_MAX;
        end
        if (sa_sum[50:47] == 4'b0000 || sa_sum[50:47] == 4'b1111) begin
          shift_acc_nxt = sa_sum[47:0];
        end else begin
          shift_acc_nxt = sa_sum[50] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
        prev_time_nxt = item_r.time_stamp;
        rem_nxt   = 37'(a_mag);
        dv_nxt    = {b_mag[34:0], 1'b0};
        q_nxt     = '0;
        div_k_nxt = '0;
      end
      teu_pkg::ST_DIV: begin
        q_nxt     = {q_r[RW-2:0], div_ge};
        rem_nxt   = {div_rem[35:0], 1'b0};
        div_k_nxt = div_k_r + DKW'(1);
        if (div_k_r == DKW'(RW - 1)) ratio_nxt = {q_r[RW-2:0], div_ge};
      end
      teu_pkg::ST_PRIME: begin
        turn_w_nxt = turn_arr_r[ch_idx];
        pext_w_nxt = pext_arr_r[ch_idx];
        href_w_nxt = href_arr_r[ch_idx];
        if (primed_r[ch_idx]) begin
          mul_a_nxt   = 64'($signed(turn_arr_r[ch_idx]));
          mul_b_nxt   = $signed({8'b0, enc_mod_r});
          mul_ret_nxt = teu_pkg::ST_UNW1_WB;
        end else begin
          mul_a_nxt   = $signed({32'b0, cnt_w});
          mul_b_nxt   = 41'(gain_sel);
          mul_ret_nxt = teu_pkg::ST_PRIME_WB;
        end
      end
      teu_pkg::ST_PRIME_WB: begin
        turn_w_nxt  = '0;
        pext_w_nxt  = {32'b0, cnt_w};
        href_w_nxt  = prod_r[71:8];
        mul_a_nxt   = '0;
        mul_b_nxt   = $signed({8'b0, enc_mod_r});
        mul_ret_nxt = teu_pkg::ST_UNW1_WB;
      end
      teu_pkg::ST_UNW1_WB: begin
        prev_raw_nxt = $signed(pext_w_r - prod_low);
      end
      teu_pkg::ST_UNW_ADJ: begin
        turn_w_nxt  = turn_new;
        mul_a_nxt   = 64'($signed(turn_new));
        mul_b_nxt   = $signed({8'b0, enc_mod_r});
        mul_ret_nxt = teu_pkg::ST_UNW2_WB;
      end
      teu_pkg::ST_UNW2_WB: begin
        ext_nxt = prod_low + {32'b0, cnt_w};
      end
      teu_pkg::ST_STEP: begin
        if (step_s64 > STEP_MAX) step_nxt = 37'(STEP_MAX);
        else if (step_s64 < -STEP_MAX) step_nxt = 37'(-STEP_MAX);
        else step_nxt = 37'(step_s64);
        mul_a_nxt   = $signed(pext_w_r);
        mul_b_nxt   = 41'(gain_sel);
        mul_ret_nxt = teu_pkg::ST_ACC_WB;
      end
      teu_pkg::ST_ACC_WB: begin
        acc_nxt     = prod_r;
        mul_a_nxt   = 64'(step_r);
        mul_b_nxt   = $signed({{(41 - RW){1'b0}}, ratio_r});
        mul_ret_nxt = teu_pkg::ST_SR_WB;
      end
      teu_pkg::ST_SR_WB: begin
        mul_a_nxt   = prod_low;
        mul_b_nxt   = 41'(gain_sel);
        mul_ret_nxt = teu_pkg::ST_T2_WB;
      end
      teu_pkg::ST_T2_WB: begin
        if ((&t2_sum[106:71]) || !(|t2_sum[106:71])) begin
          pos64_nxt = t2_sum[71:8];
        end else begin
          pos64_nxt = t2_sum[106] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
      end
      teu_pkg::ST_FIN: begin
        if (fin_fire) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_channel = item_r.channel;
          out_data_nxt.raw_count   = item_r.enc_count;
          out_data_nxt.time_fault  = fault_r;
          if (fin_diff[65:47] == '0 || fin_diff[65:47] == '1) begin
            out_data_nxt.position = fin_diff[47:0];
          end else begin
            out_data_nxt.position = fin_diff[65] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
          end
          arr_we = 1'b1;
        end
      end
      teu_pkg::ST_HOME_WB: begin
        arr_we       = 1'b1;
        arr_turn_val = '0;
        arr_pext_val = {32'b0, cnt_w};
        arr_href_val = sat64(home_diff);
      end
      teu_pkg::ST_MULPREP: begin
        mag_a_nxt   = mul_a_r[63] ? 64'(-mul_a_r) : 64'(mul_a_r);
        mag_b_nxt   = mul_b_r[40] ? 41'(-mul_b_r) : 41'(mul_b_r);
        mul_neg_nxt = mul_a_r[63] ^ mul_b_r[40];
        mul_acc_nxt = '0;
        mul_k_nxt   = '0;
      end
      teu_pkg::ST_MUL: begin
        mul_acc_nxt = mul_acc_r + (105'(mul_pp) << {mul_k_r, 4'b0000});
        mul_k_nxt   = mul_k_r + 2'd1;
      end
      teu_pkg::ST_MULFIX: begin
        prod_nxt = mul_neg_r ? -$signed({1'b0, mul_acc_r}) : $signed({1'b0, mul_acc_r});
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= teu_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      enc_mod_r     <= teu_pkg::ENC_MOD_RST;
      time_mod_r    <= teu_pkg::TIME_MOD_RST;
      period_r      <= teu_pkg::PERIOD_RST;
      for (int g = 0; g < 4; g++) gain_r[g] <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        turn_arr_r[c] <= '0;
        pext_arr_r[c] <= '0;
        href_arr_r[c] <= '0;
      end
      primed_r      <= '0;
      prev_time_r   <= '0;
      shift_acc_r   <= '0;
      ratio_r       <= RATIO_ONE;
      time_primed_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      prev_time_r   <= prev_time_nxt;
      shift_acc_r   <= shift_acc_nxt;
      ratio_r       <= ratio_nxt;
      time_primed_r <= time_primed_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          teu_pkg::REG_ENC_MOD:  enc_mod_r  <= cfg_wdata[32:0];
          teu_pkg::REG_TIME_MOD: time_mod_r <= cfg_wdata[32:0];
          teu_pkg::REG_PERIOD:   period_r   <= cfg_wdata[31:0];
          teu_pkg::REG_GAIN0:    gain_r[0]  <= cfg_wdata;
          teu_pkg::REG_GAIN1:    gain_r[1]  <= cfg_wdata;
          teu_pkg::REG_GAIN2:    gain_r[2]  <= cfg_wdata;
          teu_pkg::REG_GAIN3:    gain_r[3]  <= cfg_wdata;
          default: ;
        endcase
      end
      if (arr_we) begin
        turn_arr_r[ch_idx] <= arr_turn_val;
        pext_arr_r[ch_idx] <= arr_pext_val;
        href_arr_r[ch_idx] <= arr_href_val;
        primed_r[ch_idx]   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    fault_r    <= fault_nxt;
    turn_w_r   <= turn_w_nxt;
    pext_w_r   <= pext_w_nxt;
    href_w_r   <= href_w_nxt;
    ext_r      <= ext_nxt;
    step_r     <= step_nxt;
    prev_raw_r <= prev_raw_nxt;
    acc_r      <= acc_nxt;
    pos64_r    <= pos64_nxt;
    diff_r     <= diff_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    dv_r       <= dv_nxt;
    q_r        <= q_nxt;
    div_k_r    <= div_k_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    mul_ret_r  <= mul_ret_nxt;
    mag_a_r    <= mag_a_nxt;
    mag_b_r    <= mag_b_nxt;
    mul_neg_r  <= mul_neg_nxt;
    mul_acc_r  <= mul_acc_nxt;
    mul_k_r    <= mul_k_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == teu_pkg::ST_FIN))
    else $error("result appeared outside the final step");

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while busy");

  a_fault_only_ch0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.time_fault && out_data_r.out_channel != 2'd0))
    else $error("time fault on a channel other than 0");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == teu_pkg::ST_DIV) |-> (div_k_r < DKW'(RW)))
    else $error("divider ran past its last step");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for timestamped_encoder_unwrap: a queue-fed request driver,
// a result monitor and a behavioral predictor of the unwrap, ratio and gain path.
// Depends on teu_pkg and the timestamped_encoder_unwrap RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  SETTLE       = 80;
  localparam longint MAXR      = (64'sd1 << 18) - 1;
  localparam longint ONE_Q16   = 64'sd1 << 16;
  localparam longint P47       = 64'sd1 << 47;
  localparam longint STEP_LIM  = (64'sd1 << 36) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  teu_pkg::teu_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  teu_pkg::teu_out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [teu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [teu_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  timestamped_encoder_unwrap i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  teu_pkg::teu_in_t  pending_requests[$];
  teu_pkg::teu_out_t expected_positions[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  logic took = 1'b0;

  // Predictor state and register copies.
  longint enc_mod, time_mod, period;
  longint gain[4];
  logic [31:0] turn_cnt[4];
  logic [63:0] prev_ext[4];
  longint home_ref[4];
  bit primed[4];
  logic [31:0] prev_ts;
  longint shift_acc;
  longint ratio;
  bit ts_primed;

  // Stimulus trajectory.
  longint traj_ts;
  longint traj_cnt[4];

  function automatic logic signed [127:0] mul_wide(longint a, longint b);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    return x * y;
  endfunction

  function automatic longint sat64(logic signed [127:0] x);
    if (x > 128'sh7fffffffffffffff) return 64'sh7fffffffffffffff;
    if (x < -128'sh8000000000000000) return 64'sh8000000000000000;
    return longint'(x[63:0]);
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void write_reg(logic [teu_pkg::CFG_IDX_W-1:0] idx, logic [39:0] v);
    case (idx)
      teu_pkg::REG_ENC_MOD:  enc_mod = longint'({31'b0, v[32:0]});
      teu_pkg::REG_TIME_MOD: time_mod = longint'({31'b0, v[32:0]});
      teu_pkg::REG_PERIOD:   period = longint'({32'b0, v[31:0]});
      default:               gain[idx - teu_pkg::REG_GAIN0] = longint'(signed'(v));
    endcase
  endfunction

  function automatic void rehome(int c, longint cnt, longint value);
    longint p;
    p = sat64(mul_wide(cnt, gain[c]) >>> 8);
    turn_cnt[c] = '0;
    prev_ext[c] = cnt;
    home_ref[c] = sat64(128'(p) - 128'(value));
    primed[c] = 1'b1;
  endfunction

  function automatic bit advance_time(logic [31:0] ts);
    longint prv, now, diff, num, a, b, q;
    bit fault;
    fault = 1'b0;
    if (!ts_primed) begin
      prev_ts = ts;
      ts_primed = 1'b1;
      return 1'b0;
    end
    prv = longint'({32'b0, prev_ts});
    now = longint'({32'b0, ts});
    diff = (2 * (prv - now) > time_mod) ? now + time_mod - prv : now - prv;
    num = period - shift_acc;
    if (diff == 0) begin
      ratio = ONE_Q16;
      fault = 1'b1;
    end else if (num == 0 || ((num > 0) != (diff > 0))) begin
      ratio = 0;
    end else begin
      a = num < 0 ? -num : num;
      b = diff < 0 ? -diff : diff;
      if (a >= 4 * b) q = MAXR;
      else q = (a << 16) / b;
      ratio = q > MAXR ? MAXR : q;
    end
    shift_acc = clampl(shift_acc + diff - period, -P47, P47 - 1);
    prev_ts = ts;
    return fault;
  endfunction

  function automatic void predict_request(teu_pkg::teu_in_t r);
    int c;
    longint cnt, prev_raw, d, turn_s, step, pos;
    logic [63:0] ext;
    logic signed [127:0] acc, t2;
    bit fault;
    teu_pkg::teu_out_t e;
    c = r.channel;
    cnt = longint'({32'b0, r.enc_count});
    fault = 1'b0;
    if (r.cmd) begin
      rehome(c, cnt, longint'(r.home_value));
      return;
    end
    if (c == 0) fault = advance_time(r.time_stamp);
    if (!primed[c]) rehome(c, cnt, 0);
    turn_s = longint'(signed'(turn_cnt[c]));
    prev_raw = longint'(prev_ext[c] - 64'(turn_s * enc_mod));
    d = prev_raw - cnt;
    if (prev_raw >= -(64'sd1 << 61) && prev_raw <= (64'sd1 << 61)) begin
      if (2 * d > enc_mod) turn_cnt[c] = turn_cnt[c] + 1;
      else if (2 * d < -enc_mod) turn_cnt[c] = turn_cnt[c] - 1;
    end
    turn_s = longint'(signed'(turn_cnt[c]));
    ext = 64'(turn_s * enc_mod + cnt);
    step = clampl(longint'(ext - prev_ext[c]), -STEP_LIM, STEP_LIM);
    acc = mul_wide(longint'(prev_ext[c]), gain[c]);
    t2 = mul_wide(step * ratio, gain[c]) >>> 16;
    acc = (acc + t2) >>> 8;
    pos = sat64(128'(sat64(acc)) - 128'(home_ref[c]));
    pos = clampl(pos, -P47, P47 - 1);
    prev_ext[c] = ext;
    e.out_channel = r.channel;
    e.position = pos[47:0];
    e.raw_count = r.enc_count;
    e.time_fault = fault;
    expected_positions.push_back(e);
  endfunction

  function automatic void reset_predictor();
    enc_mod = longint'(teu_pkg::ENC_MOD_RST);
    time_mod = longint'(teu_pkg::TIME_MOD_RST);
    period = longint'(teu_pkg::PERIOD_RST);
    for (int c = 0; c < 4; c++) begin
      gain[c] = 0;
      turn_cnt[c] = '0;
      prev_ext[c] = '0;
      home_ref[c] = 0;
      primed[c] = 1'b0;
      traj_cnt[c] = 0;
    end
    prev_ts = '0;
    shift_acc = 0;
    ratio = ONE_Q16;
    ts_primed = 1'b0;
    traj_ts = 0;
  endfunction

  function automatic teu_pkg::teu_in_t make_request(bit cmd, int c, longint cnt, longint ts,
                                                    longint hv);
    teu_pkg::teu_in_t r;
    r.cmd = cmd;
    r.channel = c[1:0];
    r.enc_count = cnt[31:0];
    r.time_stamp = ts[31:0];
    r.home_value = hv[47:0];
    return r;
  endfunction

  function automatic longint rand48();
    return longint'({$urandom, $urandom}) >>> 16;
  endfunction

  function automatic longint wrapmod(longint v, longint m);
    longint r;
    r = v % m;
    return r < 0 ? r + m : r;
  endfunction

  function automatic teu_pkg::teu_in_t random_request();
    int c, k;
    longint delta, jit;
    k = $urandom_range(99);
    c = $urandom_range(3);
    if (k < 8) begin
      return make_request(1'b1, c, traj_cnt[c], traj_ts, rand48());
    end else if (k < 16) begin
      return make_request(1'($urandom_range(1)), c, longint'({32'b0, $urandom}),
                          longint'({32'b0, $urandom}), rand48());
    end
    if ($urandom_range(3) == 0) delta = longint'($urandom_range(4000)) - 2000;
    else delta = (longint'({32'b0, $urandom}) % (enc_mod / 2 + 1)) - enc_mod / 4;
    traj_cnt[c] = wrapmod(traj_cnt[c] + delta, enc_mod);
    if (c == 0 && $urandom_range(19) != 0) begin
      jit = longint'($urandom_range(200)) - 100;
      traj_ts = wrapmod(traj_ts + period + jit, time_mod);
    end
    return make_request(1'b0, c, traj_cnt[c], traj_ts, rand48());
  endfunction

  task automatic cfg_write(logic [teu_pkg::CFG_IDX_W-1:0] idx, logic [39:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    write_reg(idx, v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_positions.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_all(logic [39:0] em, logic [39:0] tm, logic [39:0] pr,
                             logic [39:0] g0, logic [39:0] g1, logic [39:0] g2,
                             logic [39:0] g3);
    cfg_write(teu_pkg::REG_ENC_MOD, em);
    cfg_write(teu_pkg::REG_TIME_MOD, tm);
    cfg_write(teu_pkg::REG_PERIOD, pr);
    cfg_write(teu_pkg::REG_GAIN0, g0);
    cfg_write(teu_pkg::REG_GAIN1, g1);
    cfg_write(teu_pkg::REG_GAIN2, g2);
    cfg_write(teu_pkg::REG_GAIN3, g3);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_requests.push_back(random_request());
    wait_drained();
  endtask

  function automatic logic [39:0] rand_gain();
    return 40'({$urandom, $urandom} >> 24);
  endfunction

  initial begin
    reset_predictor();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: first samples re-zero, gains are zero.
    pending_requests.push_back(make_request(1'b0, 0, 100, 10, 0));
    pending_requests.push_back(make_request(1'b0, 0, 200, 3916, 0));
    wait_drained();

    program_all(40'd65536, 40'd65536, 40'd3906, 40'h0100000000, 40'h8000000000,
                40'h7fffffffff, 40'hff00000000);
    pending_requests.push_back(make_request(1'b1, 1, 0, 0, 64'sh00007fffffffffff));
    pending_requests.push_back(make_request(1'b1, 2, 32'hffffffff, 0,
                                            64'shffff800000000000));
    pending_requests.push_back(make_request(1'b0, 1, 65535, 0, 0));
    pending_requests.push_back(make_request(1'b0, 1, 1, 0, 0));
    pending_requests.push_back(make_request(1'b0, 1, 65000, 0, 0));
    pending_requests.push_back(make_request(1'b0, 2, 0, 0, 0));
    pending_requests.push_back(make_request(1'b0, 2, 32'hffffffff, 0, 0));
    pending_requests.push_back(make_request(1'b0, 3, 12345, 0, 0));
    pending_requests.push_back(make_request(1'b0, 3, 40000, 0, 0));
    pending_requests.push_back(make_request(1'b0, 0, 10, 65000, 0));
    pending_requests.push_back(make_request(1'b0, 0, 20, 65000, 0));
    pending_requests.push_back(make_request(1'b0, 0, 4000, 3370, 0));
    pending_requests.push_back(make_request(1'b0, 0, 8000, 100, 0));
    pending_requests.push_back(make_request(1'b0, 0, 60000, 7500, 0));
    pending_requests.push_back(make_request(1'b1, 0, 500, 0, 64'sh0000000001000000));
    pending_requests.push_back(make_request(1'b0, 0, 600, 11406, 0));
    pending_requests.push_back(make_request(1'b0, 0, 65535, 32'hffffffff, 0));
    pending_requests.push_back(make_request(1'b0, 3, 0, 0, 0));
    wait_drained();

    random_phase(270);

    program_all(40'h100000000, 40'h100000000, 40'hffffffff, 40'h7fffffffff,
                40'h8000000000, rand_gain(), rand_gain());
    random_phase(270);

    quiet = 1'b1;
    program_all(40'd4096, 40'd100000, 40'd997, rand_gain(), rand_gain(),
                rand_gain(), rand_gain());
    random_phase(270);
    quiet = 1'b0;

    program_all(40'd2, 40'd2, 40'd1, 40'h8000000000, 40'h7fffffffff,
                rand_gain(), rand_gain());
    random_phase(270);

    program_all(40'd65536, 40'd65536, 40'd3906, rand_gain(), rand_gain(),
                rand_gain(), rand_gain());
    random_phase(270);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      if (pending_requests.size() != 0 && (quiet || $urandom_range(99) >= 32)) begin
        in_valid <= 1'b1;
        in_data <= pending_requests.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 32);
  end

  always @(posedge clk) begin
    teu_pkg::teu_out_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
    took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) predict_request(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", out_data);
      end else begin
        e = expected_positions.pop_front();
        if (out_data.out_channel !== e.out_channel || out_data.position !== e.position ||
            out_data.raw_count !== e.raw_count || out_data.time_fault !== e.time_fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

endmodule
